// ----- design/stt_pkg.sv -----
package stt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 24;
   localparam int FIELD_BITS          = 24;

   // result queue depth; one item can push up to two results
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PUSH_MAX  = 2;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_SPACE      = 8'd32;
   localparam logic [7:0] CHAR_HIGH_FIRST = 8'd128;
   localparam logic [7:0] CHAR_MINUS      = 8'h2d;
   localparam logic [7:0] CHAR_DOT        = 8'h2e;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7a;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5a;

   localparam logic [2:0] KIND_IDENT  = 3'd0;
   localparam logic [2:0] KIND_NUMBER = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_PUNCT  = 3'd3;
   localparam logic [2:0] KIND_EOF    = 3'd4;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_STRING = 2'd3
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_marker;
   } req_type;

   typedef struct packed {
      logic [2:0]            token_kind;
      logic [FIELD_BITS-1:0] token_start;
      logic [FIELD_BITS-1:0] token_length;
      logic                  last_of_run;
   } rsp_type;

   // results of one item, in emission order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

endpackage

// ----- design/source_text_tokenizer.sv -----
// Source text tokenizer: takes one byte of text per transaction and returns one record per
// token (kind, start offset, length). Bytes are scanned at one per clock: the scan state
// update is a single combinational step feeding a four-entry result queue, so an item is
// accepted every cycle while that queue holds two or fewer results. Most bytes produce zero
// or one result; a byte that both ends an identifier or number and is punctuation, and the
// end-of-file item when a token is open, produce two, which drain one per cycle on the
// result side while rsp_stall is low; results are registered in the queue. After a zero
// byte, bytes are only counted until the end-of-file item, which clears all state.
module source_text_tokenizer #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stt_pkg::rsp_type rsp_payload
);

   stt_pkg::scan_mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] open_start_ff, open_start_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   halted_ff, halted_in;
   stt_pkg::emit_type      emit;
   logic                   room;
   logic                   accept;
   logic [1:0]             push_count;

   assign req_stall  = !room;
   assign accept     = req_valid && room;
   assign push_count = accept ? emit.count : 2'd0;

   stt_scan #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_scan (
      .req           (req_payload),
      .mode          (mode_ff),
      .open_start    (open_start_ff),
      .offset        (offset_ff),
      .halted        (halted_ff),
      .mode_in       (mode_in),
      .open_start_in (open_start_in),
      .offset_in     (offset_in),
      .halted_in     (halted_in),
      .emit          (emit)
   );

   stt_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (emit.first),
      .push_second (emit.second),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= stt_pkg::MODE_IDLE;
         open_start_ff <= '0;
         offset_ff     <= '0;
         halted_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         open_start_ff <= open_start_in;
         offset_ff     <= offset_in;
         halted_ff     <= halted_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_marker |=>
         mode_ff == stt_pkg::MODE_IDLE && offset_ff == '0 && !halted_ff)
      else $error("end of file did not clear scan state");
   a_halt_no_open: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> mode_ff == stt_pkg::MODE_IDLE)
      else $error("token open after zero byte");
`endif

endmodule

// ----- design/stt_scan.sv -----
module stt_scan #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT
) (
   input  stt_pkg::req_type       req,
   input  stt_pkg::scan_mode_type mode,
   input  logic [OFFSET_BITS-1:0] open_start,
   input  logic [OFFSET_BITS-1:0] offset,
   input  logic                   halted,
   output stt_pkg::scan_mode_type mode_in,
   output logic [OFFSET_BITS-1:0] open_start_in,
   output logic [OFFSET_BITS-1:0] offset_in,
   output logic                   halted_in,
   output stt_pkg::emit_type      emit
);

   logic [7:0] b;
   logic       is_letter;
   logic       is_digit;
   logic       is_nul;
   logic       is_sep;
   logic       is_quote;
   logic       closes_open;
   logic       starts_punct;
   stt_pkg::scan_mode_type eff_mode;
   logic [OFFSET_BITS-1:0] len_plain;
   logic [OFFSET_BITS-1:0] len_open;
   logic [2:0]             open_kind;
   stt_pkg::rsp_type       open_rec;
   stt_pkg::rsp_type       eof_rec;
   stt_pkg::rsp_type       punct_rec;

   assign b = req.data_byte;
   assign is_letter = (b >= stt_pkg::CHAR_LOWER_A && b <= stt_pkg::CHAR_LOWER_Z)
                   || (b >= stt_pkg::CHAR_UPPER_A && b <= stt_pkg::CHAR_UPPER_Z)
                   || b == stt_pkg::CHAR_UNDERSCORE || b == stt_pkg::CHAR_DOLLAR;
   assign is_digit = b >= stt_pkg::CHAR_ZERO && b <= stt_pkg::CHAR_NINE;
   assign is_nul   = b == stt_pkg::CHAR_NUL;
   assign is_sep   = b <= stt_pkg::CHAR_SPACE || b >= stt_pkg::CHAR_HIGH_FIRST;
   assign is_quote = b == stt_pkg::CHAR_QUOTE;

   // an identifier or number ends at the first byte that cannot continue it
   assign closes_open = (mode == stt_pkg::MODE_IDENT && !(is_letter || is_digit))
                     || (mode == stt_pkg::MODE_NUMBER && !(is_digit || b == stt_pkg::CHAR_DOT));
   assign eff_mode = closes_open ? stt_pkg::MODE_IDLE : mode;
   assign starts_punct = eff_mode == stt_pkg::MODE_IDLE && !is_sep && !is_letter
                      && !is_digit && b != stt_pkg::CHAR_MINUS && !is_quote;

   assign len_plain = offset - open_start;
   // closing quote belongs to the string
   assign len_open  = (mode == stt_pkg::MODE_STRING && is_quote && !req.end_marker)
                    ? len_plain + OFFSET_BITS'(1) : len_plain;

   always_comb begin
      unique case (mode)
         stt_pkg::MODE_IDENT:  open_kind = stt_pkg::KIND_IDENT;
         stt_pkg::MODE_NUMBER: open_kind = stt_pkg::KIND_NUMBER;
         stt_pkg::MODE_STRING: open_kind = stt_pkg::KIND_STRING;
         default:              open_kind = stt_pkg::KIND_PUNCT;
      endcase
   end

   assign open_rec  = '{token_kind: open_kind,
                        token_start: stt_pkg::FIELD_BITS'(open_start),
                        token_length: stt_pkg::FIELD_BITS'(len_open),
                        last_of_run: 1'b0};
   assign eof_rec   = '{token_kind: stt_pkg::KIND_EOF,
                        token_start: stt_pkg::FIELD_BITS'(offset),
                        token_length: '0,
                        last_of_run: 1'b0};
   assign punct_rec = '{token_kind: stt_pkg::KIND_PUNCT,
                        token_start: stt_pkg::FIELD_BITS'(offset),
                        token_length: stt_pkg::FIELD_BITS'(1),
                        last_of_run: 1'b0};

   // next state
   always_comb begin
      mode_in       = mode;
      open_start_in = open_start;
      offset_in     = offset + OFFSET_BITS'(1);
      halted_in     = halted;
      if (req.end_marker) begin
         mode_in       = stt_pkg::MODE_IDLE;
         open_start_in = '0;
         offset_in     = '0;
         halted_in     = 1'b0;
      end else if (halted) begin
         // only counting bytes
      end else if (mode == stt_pkg::MODE_STRING) begin
         if (is_nul) begin
            mode_in   = stt_pkg::MODE_IDLE;
            halted_in = 1'b1;
         end else if (is_quote) begin
            mode_in = stt_pkg::MODE_IDLE;
         end
      end else begin
         mode_in = eff_mode;
         if (eff_mode == stt_pkg::MODE_IDLE) begin
            if (is_nul) begin
               halted_in = 1'b1;
            end else if (is_sep) begin
               // separator
            end else if (is_letter) begin
               mode_in       = stt_pkg::MODE_IDENT;
               open_start_in = offset;
            end else if (is_digit || b == stt_pkg::CHAR_MINUS) begin
               mode_in       = stt_pkg::MODE_NUMBER;
               open_start_in = offset;
            end else if (is_quote) begin
               mode_in       = stt_pkg::MODE_STRING;
               open_start_in = offset;
            end
         end
      end
   end

   // results
   always_comb begin
      emit = '{count: 2'd0, first: open_rec, second: eof_rec};
      if (req.end_marker) begin
         if (mode != stt_pkg::MODE_IDLE) begin
            emit.count = 2'd2;
         end else begin
            emit.count = 2'd1;
            emit.first = eof_rec;
         end
      end else if (halted) begin
         emit.count = 2'd0;
      end else if (mode == stt_pkg::MODE_STRING) begin
         if (is_nul || is_quote) begin
            emit.count = 2'd1;
         end
      end else begin
         emit.second = punct_rec;
         if (closes_open && starts_punct) begin
            emit.count = 2'd2;
         end else if (closes_open) begin
            emit.count = 2'd1;
         end else if (starts_punct) begin
            emit.count = 2'd1;
            emit.first = punct_rec;
         end
      end
      emit.first.last_of_run  = emit.count == 2'd1;
      emit.second.last_of_run = 1'b1;
   end

endmodule

// ----- design/stt_rsp_fifo.sv -----
module stt_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_count,
   input  stt_pkg::rsp_type  push_first,
   input  stt_pkg::rsp_type  push_second,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stt_pkg::rsp_type  rsp_payload
);

   localparam int PTR_BITS = $clog2(stt_pkg::RSP_DEPTH);
   localparam int CNT_BITS = $clog2(stt_pkg::RSP_DEPTH + 1);

   stt_pkg::rsp_type mem [stt_pkg::RSP_DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                pop;

   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = mem[rd_ptr_ff];
   // room for the largest burst one item can push
   assign room = count_ff <= CNT_BITS'(stt_pkg::RSP_DEPTH - stt_pkg::RSP_PUSH_MAX);

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + CNT_BITS'(push_count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_ff + PTR_BITS'(1)] <= push_second;
      end
   end

`ifndef NO_ASSERTIONS
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |->
         (CNT_BITS + 1)'(count_ff) + (CNT_BITS + 1)'(push_count)
            <= (CNT_BITS + 1)'(stt_pkg::RSP_DEPTH))
      else $error("result queue overflow");
   a_occupancy_matches_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff != CNT_BITS'(stt_pkg::RSP_DEPTH) |->
         PTR_BITS'(count_ff) == PTR_BITS'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue count disagrees with pointers");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 75;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   stt_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   stt_pkg::rsp_type rsp_payload;

   source_text_tokenizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   stt_pkg::req_type pending_bytes[$];
   stt_pkg::rsp_type expected_tokens[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int issued_cnt    = 0;
   int accepted_cnt  = 0;
   int queued_cnt    = 0;
   int eof_cnt       = 0;
   int tokens_seen   = 0;
   int double_cnt    = 0;
   int fail_cnt      = 0;
   int cycle_cnt     = 0;

   // tokenizer state mirror
   stt_pkg::scan_mode_type         scan_st    = stt_pkg::MODE_IDLE;
   logic [stt_pkg::FIELD_BITS-1:0] open_start = '0;
   logic [stt_pkg::FIELD_BITS-1:0] byte_pos   = '0;
   logic                           nul_seen   = 1'b0;

   function automatic logic is_letter(logic [7:0] b);
      return (b >= stt_pkg::CHAR_LOWER_A && b <= stt_pkg::CHAR_LOWER_Z) ||
             (b >= stt_pkg::CHAR_UPPER_A && b <= stt_pkg::CHAR_UPPER_Z) ||
             b == stt_pkg::CHAR_UNDERSCORE || b == stt_pkg::CHAR_DOLLAR;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= stt_pkg::CHAR_ZERO && b <= stt_pkg::CHAR_NINE;
   endfunction

   function automatic stt_pkg::rsp_type make_token(logic [2:0] kind,
                                                   logic [stt_pkg::FIELD_BITS-1:0] start,
                                                   logic [stt_pkg::FIELD_BITS-1:0] len);
      stt_pkg::rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   function automatic stt_pkg::rsp_type close_open(logic [stt_pkg::FIELD_BITS-1:0] extra);
      logic [2:0] kind;
      case (scan_st)
         stt_pkg::MODE_IDENT:  kind = stt_pkg::KIND_IDENT;
         stt_pkg::MODE_NUMBER: kind = stt_pkg::KIND_NUMBER;
         default:              kind = stt_pkg::KIND_STRING;
      endcase
      scan_st = stt_pkg::MODE_IDLE;
      return make_token(kind, open_start, byte_pos - open_start + extra);
   endfunction

   function automatic void tokenize_item(stt_pkg::req_type r);
      stt_pkg::rsp_type step_out[3];
      int               n;
      logic [7:0]       b;
      n = 0;
      b = r.data_byte;
      if (r.end_marker) begin
         if (scan_st != stt_pkg::MODE_IDLE) begin
            step_out[n] = close_open('0);
            n++;
         end
         step_out[n] = make_token(stt_pkg::KIND_EOF, byte_pos, '0);
         n++;
         scan_st    = stt_pkg::MODE_IDLE;
         open_start = '0;
         byte_pos   = '0;
         nul_seen   = 1'b0;
      end else if (nul_seen) begin
         byte_pos++;
      end else begin
         if (scan_st == stt_pkg::MODE_STRING) begin
            if (b == stt_pkg::CHAR_NUL) begin
               step_out[n] = close_open('0);
               n++;
               nul_seen = 1'b1;
            end else if (b == stt_pkg::CHAR_QUOTE) begin
               step_out[n] = close_open(stt_pkg::FIELD_BITS'(1));
               n++;
            end
         end else begin
            if (scan_st == stt_pkg::MODE_IDENT && !(is_letter(b) || is_digit(b))) begin
               step_out[n] = close_open('0);
               n++;
            end else if (scan_st == stt_pkg::MODE_NUMBER &&
                         !(is_digit(b) || b == stt_pkg::CHAR_DOT)) begin
               step_out[n] = close_open('0);
               n++;
            end
            if (scan_st == stt_pkg::MODE_IDLE) begin
               if (b == stt_pkg::CHAR_NUL) begin
                  nul_seen = 1'b1;
               end else if (b > stt_pkg::CHAR_SPACE && b < stt_pkg::CHAR_HIGH_FIRST) begin
                  if (is_letter(b)) begin
                     scan_st    = stt_pkg::MODE_IDENT;
                     open_start = byte_pos;
                  end else if (is_digit(b) || b == stt_pkg::CHAR_MINUS) begin
                     scan_st    = stt_pkg::MODE_NUMBER;
                     open_start = byte_pos;
                  end else if (b == stt_pkg::CHAR_QUOTE) begin
                     scan_st    = stt_pkg::MODE_STRING;
                     open_start = byte_pos;
                  end else begin
                     step_out[n] = make_token(stt_pkg::KIND_PUNCT, byte_pos,
                                              stt_pkg::FIELD_BITS'(1));
                     n++;
                  end
               end
            end
         end
         byte_pos++;
      end
      if (n > 0) step_out[n-1].last_of_run = 1'b1;
      if (n > 1) double_cnt++;
      for (int i = 0; i < n; i++) expected_tokens = {expected_tokens, step_out[i]};
   endfunction

   // stimulus helpers
   task automatic push_byte(logic [7:0] b);
      pending_bytes = {pending_bytes, stt_pkg::req_type'{data_byte: b, end_marker: 1'b0}};
      queued_cnt++;
   endtask

   task automatic push_eof();
      pending_bytes = {pending_bytes,
                       stt_pkg::req_type'{data_byte: 8'($urandom_range(255)),
                                          end_marker: 1'b1}};
      queued_cnt++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_letter();
      int k;
      k = $urandom_range(53);
      if (k < 26) return stt_pkg::CHAR_LOWER_A + 8'(k);
      if (k < 52) return stt_pkg::CHAR_UPPER_A + 8'(k - 26);
      if (k == 52) return stt_pkg::CHAR_UNDERSCORE;
      return stt_pkg::CHAR_DOLLAR;
   endfunction

   function automatic logic [7:0] pick_digit();
      return stt_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] pick_sep();
      if ($urandom_range(1)) return 8'($urandom_range(1, 32));
      return 8'($urandom_range(128, 255));
   endfunction

   function automatic logic [7:0] pick_string_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (b == stt_pkg::CHAR_QUOTE) b = stt_pkg::CHAR_DOT;
      return b;
   endfunction

   // one plausible file: a run of tokens with random content, then end of file
   task automatic push_random_file();
      int ntok;
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               push_byte(pick_letter());
               repeat ($urandom_range(5))
                  push_byte($urandom_range(1) ? pick_letter() : pick_digit());
            end
            3, 4: begin
               push_byte($urandom_range(3) == 0 ? stt_pkg::CHAR_MINUS : pick_digit());
               repeat ($urandom_range(4))
                  push_byte($urandom_range(2) == 0 ? stt_pkg::CHAR_DOT : pick_digit());
            end
            5: begin
               push_byte(stt_pkg::CHAR_QUOTE);
               repeat ($urandom_range(5)) push_byte(pick_string_byte());
               if ($urandom_range(7) != 0) push_byte(stt_pkg::CHAR_QUOTE);
            end
            6, 7: push_byte(8'($urandom_range(33, 127)));
            8: push_byte(pick_sep());
            default: push_byte($urandom_range(5) == 0 ? stt_pkg::CHAR_NUL : pick_sep());
         endcase
         if ($urandom_range(1)) push_byte(pick_sep());
      end
      push_eof();
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || accepted_cnt != issued_cnt ||
             expected_tokens.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted_cnt == issued_cnt) begin
         if (pending_bytes.size() == 0 || $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
         end else begin
            req_payload <= pending_bytes.pop_front();
            req_valid   <= 1'b1;
            issued_cnt++;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor and checker
   always @(posedge clock) begin
      stt_pkg::rsp_type want;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("source_text_tokenizer: mismatch");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tokenize_item(req_payload);
            if (req_payload.end_marker) eof_cnt++;
            accepted_cnt++;
         end
         if (rsp_valid && !rsp_stall) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               $error("unexpected token transaction: kind %0d start %0d length %0d",
                      rsp_payload.token_kind, rsp_payload.token_start,
                      rsp_payload.token_length);
               fail_cnt++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_payload.token_kind !== want.token_kind) begin
                  $error("token_kind expected %0d actual %0d",
                         want.token_kind, rsp_payload.token_kind);
                  fail_cnt++;
               end
               if (rsp_payload.token_start !== want.token_start) begin
                  $error("token_start expected %0d actual %0d",
                         want.token_start, rsp_payload.token_start);
                  fail_cnt++;
               end
               if (rsp_payload.token_length !== want.token_length) begin
                  $error("token_length expected %0d actual %0d",
                         want.token_length, rsp_payload.token_length);
                  fail_cnt++;
               end
               if (rsp_payload.last_of_run !== want.last_of_run) begin
                  $error("last_of_run expected %0d actual %0d",
                         want.last_of_run, rsp_payload.last_of_run);
                  fail_cnt++;
               end
            end
         end
      end
   end

   int send_pcts[4]  = '{0, 82, 0, 7};
   int stall_pcts[4] = '{0, 0, 82, 7};

   initial begin
      int phase_start;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: empty file, every token class, adjacency, separators, open string at
      // end of file, zero byte inside a string followed by counted-only bytes
      push_eof();
      push_text("_$9 -1.+\"x\"b;7z");
      push_byte(stt_pkg::CHAR_HIGH_FIRST);
      push_byte(8'hff);
      push_byte(8'h7f);
      push_byte(8'h01);
      push_text("!\"o");
      push_eof();
      push_text("\"q");
      push_byte(stt_pkg::CHAR_NUL);
      push_text("z");
      push_eof();
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_pcts[ph];
         rsp_stall_pct = stall_pcts[ph];
         phase_start   = queued_cnt;
         while (queued_cnt - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 75) begin
               push_random_file();
            end else begin
               repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
               if ($urandom_range(9) == 0) push_eof();
            end
         end
         // sender holds off until every token of this phase has come back
         drain();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $error("%0d tokens never arrived", expected_tokens.size());
         fail_cnt++;
      end
      $display("run covered %0d input transactions (%0d end of file) and %0d tokens,",
               accepted_cnt, eof_cnt, tokens_seen);
      $display("%0d steps gave two tokens, under four idle/stall mixes", double_cnt);
      if (fail_cnt == 0) begin
         $display("source_text_tokenizer: match");
      end else begin
         $display("source_text_tokenizer: mismatch");
      end
      $finish;
   end

endmodule
